FILE: design/rxfa_pkg.sv
// ----------------------------------------------------------------------------
// rxfa_pkg: shared definitions for the serial receive frame assembler
// Buffer geometry, field widths, character codes, register map and the
// structures passed between the assembler's modules.
// ----------------------------------------------------------------------------
package rxfa_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  localparam int BYTE_W    = 8;
  localparam int FLEN_W    = 7;
  localparam int TICK_W    = 8;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam byte_t CH_CR  = 8'd13;
  localparam byte_t CH_LF  = 8'd10;
  localparam byte_t CH_NUL = 8'd0;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_TEXT_MODE  = 2'd0;
  localparam logic [1:0] REG_END_CHAR   = 2'd1;
  localparam logic [1:0] REG_IDLE_TICKS = 2'd2;

  localparam logic              RST_TEXT_MODE  = 1'b0;
  localparam byte_t             RST_END_CHAR   = 8'd13;
  localparam logic [TICK_W-1:0] RST_IDLE_TICKS = 8'd10;

  typedef struct packed {
    logic              text_mode;
    byte_t             end_char;
    logic [TICK_W-1:0] idle_ticks;
  } cfg_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    byte_t data;
  } mem_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } mem_rd_t;

endpackage

FILE: design/serial_rx_frame_assembler_core.sv
// ----------------------------------------------------------------------------
// serial_rx_frame_assembler_core: serial receive frame assembler
// Gathers received bytes into a 64-byte buffer and emits closed frames.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries requests: a received byte (operation 0) or one
// timer tick (operation 1), taken while in_stall is low. In binary mode a tick
// that finds the idle countdown at zero closes a non-empty frame that did not
// overflow; in text mode the end character or a zero byte closes it. A closed
// frame leaves on the output channel as one request per byte, in arrival
// order, with its length, overflow mark and a last-byte flag. The first byte
// appears once the drain state issues a registered buffer read, then one byte
// per cycle while the receiver does not stall, set by the single read port of
// the frame buffer. While a frame drains, in_stall is high; when the receiver
// stalls, the current output byte holds and draining pauses. Reset clears the
// counters, overflow flag and output valid; buffer contents are not cleared
// and need no clearing pass. Configuration registers sit at byte addresses 0,
// 4 and 8; the user must write them only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module serial_rx_frame_assembler_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_frame_byte,
  output logic [rxfa_pkg::FLEN_W-1:0]    out_frame_length,
  output logic                           out_overflowed,
  output logic                           out_last_byte,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [rxfa_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [rxfa_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [rxfa_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import rxfa_pkg::*;

  cfg_t    cfg;
  mem_wr_t mem_wr;
  mem_rd_t mem_rd;
  byte_t   rd_data;
  cnt_t    out_len;

  rxfa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rxfa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_len      (out_len),
    .out_ovf      (out_overflowed),
    .out_last     (out_last_byte),
    .mem_wr       (mem_wr),
    .mem_rd       (mem_rd)
  );

  rxfa_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  assign out_frame_byte   = rd_data;
  assign out_frame_length = FLEN_W'(out_len);

endmodule

FILE: design/rxfa_mem.sv
// ----------------------------------------------------------------------------
// rxfa_mem: frame buffer
// Single-write, single-read synchronous memory holding the bytes of the
// frame being gathered. Read data is registered and held when not read.
// ----------------------------------------------------------------------------
module rxfa_mem (
  input  logic             clk,
  input  rxfa_pkg::mem_wr_t wr,
  input  rxfa_pkg::mem_rd_t rd,
  output rxfa_pkg::byte_t   rd_data
);
  import rxfa_pkg::*;

  byte_t mem_r [BUF_DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/rxfa_regs.sv
// ----------------------------------------------------------------------------
// rxfa_regs: configuration registers
// APB-style register file holding the framing mode, end character and
// idle timeout. Writes to an unused address are ignored.
// ----------------------------------------------------------------------------
module rxfa_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rxfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [rxfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [rxfa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output rxfa_pkg::cfg_t                 cfg
);
  import rxfa_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;
  cfg_t       cfg_r;
  cfg_t       cfg_nxt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TEXT_MODE:  cfg_nxt.text_mode  = pwdata[0];
        REG_END_CHAR:   cfg_nxt.end_char   = pwdata[BYTE_W-1:0];
        REG_IDLE_TICKS: cfg_nxt.idle_ticks = pwdata[TICK_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEXT_MODE:  prdata = PDATA_W'(cfg_r.text_mode);
      REG_END_CHAR:   prdata = PDATA_W'(cfg_r.end_char);
      REG_IDLE_TICKS: prdata = PDATA_W'(cfg_r.idle_ticks);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_mode  <= RST_TEXT_MODE;
      cfg_r.end_char   <= RST_END_CHAR;
      cfg_r.idle_ticks <= RST_IDLE_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/rxfa_ctrl.sv
// ----------------------------------------------------------------------------
// rxfa_ctrl: framing control
// Tracks fill count, idle countdown and overflow, writes received bytes to the
// buffer and reads a closed frame back out one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module rxfa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rxfa_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  rxfa_pkg::byte_t             in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rxfa_pkg::cnt_t              out_len,
  output logic                        out_ovf,
  output logic                        out_last,
  output rxfa_pkg::mem_wr_t           mem_wr,
  output rxfa_pkg::mem_rd_t           mem_rd
);
  import rxfa_pkg::*;

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t            state_r,     state_nxt;
  cnt_t              count_r,     count_nxt;
  logic [TICK_W-1:0] countdown_r, countdown_nxt;
  logic              ovf_r,       ovf_nxt;
  cnt_t              drain_len_r, drain_len_nxt;
  cnt_t              drain_idx_r, drain_idx_nxt;
  logic              drain_ovf_r, drain_ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  cnt_t              out_len_r,   out_len_nxt;
  logic              out_ovf_r,   out_ovf_nxt;
  logic              out_last_r,  out_last_nxt;

  logic in_accept;
  logic full;
  cnt_t count_inc;
  cnt_t idx_inc;
  logic rd_issue;
  logic is_term;

  assign in_stall  = (state_r == ST_DRAIN);
  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(BUF_DEPTH));
  assign count_inc = full ? count_r : count_r + CNT_W'(1);
  assign idx_inc   = drain_idx_r + CNT_W'(1);
  assign is_term   = (in_rx_byte == cfg.end_char) || (in_rx_byte == CH_NUL);

  // A read is issued only when the output register is empty or being taken.
  assign rd_issue  = (state_r == ST_DRAIN) && (!out_valid_r || !out_stall);

  assign mem_wr.en   = in_accept && (in_operation == OP_BYTE) && !full;
  assign mem_wr.addr = count_r[ADDR_W-1:0];
  assign mem_wr.data = in_rx_byte;
  assign mem_rd.en   = rd_issue;
  assign mem_rd.addr = drain_idx_r[ADDR_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    countdown_nxt = countdown_r;
    ovf_nxt       = ovf_r;
    drain_len_nxt = drain_len_r;
    drain_idx_nxt = drain_idx_r;
    drain_ovf_nxt = drain_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_operation == OP_BYTE) begin
            countdown_nxt = cfg.idle_ticks;
            count_nxt     = count_inc;
            ovf_nxt       = ovf_r | full;
            if (cfg.text_mode) begin
              // A CR or LF landing in the first slot is thrown away.
              if ((count_r == '0) && ((in_rx_byte == CH_CR) || (in_rx_byte == CH_LF))) begin
                count_nxt = '0;
              end else if (is_term) begin
                state_nxt     = ST_DRAIN;
                drain_len_nxt = count_inc;
                drain_idx_nxt = '0;
                drain_ovf_nxt = ovf_r | full;
                count_nxt     = '0;
                ovf_nxt       = 1'b0;
              end
            end
          end else begin
            if (countdown_r != '0) begin
              countdown_nxt = countdown_r - TICK_W'(1);
            end else if (ovf_r) begin
              ovf_nxt   = 1'b0;
              count_nxt = '0;
            end else if ((count_r != '0) && !cfg.text_mode) begin
              state_nxt     = ST_DRAIN;
              drain_len_nxt = count_r;
              drain_idx_nxt = '0;
              drain_ovf_nxt = 1'b0;
              count_nxt     = '0;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (rd_issue) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = drain_len_r;
          out_ovf_nxt   = drain_ovf_r;
          out_last_nxt  = (idx_inc == drain_len_r);
          drain_idx_nxt = idx_inc;
          if (idx_inc == drain_len_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      countdown_r <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      countdown_r <= countdown_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    drain_len_r <= drain_len_nxt;
    drain_idx_r <= drain_idx_nxt;
    drain_ovf_r <= drain_ovf_nxt;
    out_len_r   <= out_len_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_len   = out_len_r;
  assign out_ovf   = out_ovf_r;
  assign out_last  = out_last_r;

endmodule
